FILE: rtl/tswt_pkg.sv
package tswt_pkg;

  localparam int unsigned MaxSamplesDef = 16;
  localparam int unsigned SampleBitsDef = 16;

  localparam int unsigned ThrW    = 15;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned ValW    = 33;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_TEST_MODE = 2'd1
  } reg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_MEAN   = 2'd0,
    MODE_MEDIAN = 2'd1,
    MODE_ALL    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_EVAL    = 2'b10
  } state_e;

  function automatic logic in_window(logic [ValW-1:0] v, logic [ThrW-1:0] thr);
    logic [ValW-1:0] lo;
    logic [ValW-1:0] hi;
    lo = ValW'(thr);
    hi = ValW'({thr, 1'b0});
    return (v > lo) && (v < hi);
  endfunction

endpackage

FILE: rtl/tswt_cell.sv
module tswt_cell #(
  parameter int unsigned SAMPLE_BITS = tswt_pkg::SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   insert_i,
  input  logic                   occupied_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   left_gt_i,
  input  logic [SAMPLE_BITS-1:0] left_val_i,
  output logic                   gt_o,
  output logic [SAMPLE_BITS-1:0] val_o
);

  logic [SAMPLE_BITS-1:0] val_q;
  logic [SAMPLE_BITS-1:0] val_d;

  assign gt_o  = occupied_i && (val_q > sample_i);
  assign val_o = val_q;

  // The new word lands in the first cell holding a larger value, or in the
  // first free cell; every larger value moves one cell to the right.
  always_comb begin
    val_d = val_q;
    if (left_gt_i) begin
      val_d = left_val_i;
    end else if (gt_o || !occupied_i) begin
      val_d = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert_i) begin
      val_q <= val_d;
    end
  end

endmodule

FILE: rtl/tswt_judge.sv
module tswt_judge #(
  parameter int unsigned MAX_SAMPLES = tswt_pkg::MaxSamplesDef,
  parameter int unsigned SAMPLE_BITS = tswt_pkg::SampleBitsDef,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW = SAMPLE_BITS + CntW
) (
  input  logic [tswt_pkg::ThrW-1:0]  thr_i,
  input  logic [tswt_pkg::ModeW-1:0] mode_i,
  input  logic [SumW-1:0]            sum_i,
  input  logic [CntW-1:0]            count_i,
  input  logic [SAMPLE_BITS-1:0]     mid_val_i,
  input  logic                       all_in_i,
  output logic                       verdict_o
);

  localparam int unsigned ProdW = tswt_pkg::ThrW + 1 + CntW;
  localparam int unsigned MW    = tswt_pkg::ValW + CntW;

  logic [tswt_pkg::ThrW:0] t_lo;
  logic [tswt_pkg::ThrW:0] t_hi;
  logic [ProdW-1:0]        p_lo;
  logic [ProdW-1:0]        p_hi;
  logic                    mean_ok;
  logic                    median_ok;
  logic                    nonempty;

  // The truncated mean q = sum / count lies in the window exactly when
  // (thr + 1) * count <= sum and sum < 2 * thr * count.
  assign t_lo = {1'b0, thr_i} + (tswt_pkg::ThrW + 1)'(1);
  assign t_hi = {thr_i, 1'b0};
  assign p_lo = ProdW'(t_lo) * ProdW'(count_i);
  assign p_hi = ProdW'(t_hi) * ProdW'(count_i);

  assign nonempty  = (count_i != '0);
  assign mean_ok   = nonempty && (MW'(sum_i) >= MW'(p_lo)) && (MW'(sum_i) < MW'(p_hi));
  assign median_ok = nonempty &&
                     tswt_pkg::in_window(tswt_pkg::ValW'(mid_val_i), thr_i);

  always_comb begin
    case (mode_i)
      tswt_pkg::MODE_MEAN:   verdict_o = mean_ok;
      tswt_pkg::MODE_MEDIAN: verdict_o = median_ok;
      tswt_pkg::MODE_ALL:    verdict_o = all_in_i;
      default:               verdict_o = 1'b0;
    endcase
  end

endmodule

FILE: rtl/timing_sample_window_test_core.sv
// Collects a run of latency samples and gives one pass or fail word when the
// sample marked last has been taken. Samples are kept in ascending order by a
// chain of insertion cells, one cell per stored sample, which takes a new
// sample every cycle while the input is not stalled. After the last sample the
// core enters a verdict state, in which the input is stalled and the mean test
// (two small multiplies and compares), the median pick from the chain and the
// all-pass flag are resolved. The verdict state waits while an earlier result
// is still held in the output register. Samples beyond MAX_SAMPLES are dropped
// and reported through overflow_o.
module timing_sample_window_test_core #(
  parameter int unsigned MAX_SAMPLES = tswt_pkg::MaxSamplesDef,
  parameter int unsigned SAMPLE_BITS = tswt_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tswt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tswt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          verdict_o,
  output logic                          overflow_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = SAMPLE_BITS + CntW;
  localparam int unsigned IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  tswt_pkg::state_e state_q, state_d;

  logic [tswt_pkg::ThrW-1:0]  thr_q;
  logic [tswt_pkg::ModeW-1:0] mode_q;
  logic [CntW-1:0]            count_q, count_d;
  logic [SumW-1:0]            sum_q, sum_d;
  logic                       all_in_q, all_in_d;
  logic                       ovf_q, ovf_d;
  logic                       out_valid_q, out_valid_d;
  logic                       verdict_q, verdict_d;
  logic                       ovf_out_q, ovf_out_d;

  logic                       in_acc;
  logic                       has_room;
  logic                       insert;
  logic                       slot_free;
  logic                       eval_fire;
  logic                       judge_verdict;
  logic [CntW-1:0]            mid;
  logic [IdxW-1:0]            mid_idx;

  logic [SAMPLE_BITS-1:0]     cell_val [MAX_SAMPLES];
  logic                       cell_gt  [MAX_SAMPLES];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q == tswt_pkg::ST_EVAL);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign has_room    = (count_q < CntW'(MAX_SAMPLES));
  assign insert      = in_acc && has_room;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign eval_fire   = (state_q == tswt_pkg::ST_EVAL) && slot_free;

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic                   left_gt;
    logic [SAMPLE_BITS-1:0] left_val;
    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_body
      assign left_gt  = cell_gt[i-1];
      assign left_val = cell_val[i-1];
    end

    tswt_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .insert_i  (insert),
      .occupied_i(count_q > CntW'(i)),
      .sample_i  (sample_i),
      .left_gt_i (left_gt),
      .left_val_i(left_val),
      .gt_o      (cell_gt[i]),
      .val_o     (cell_val[i])
    );
  end

  assign mid     = count_q >> 1;
  assign mid_idx = mid[IdxW-1:0];

  tswt_judge #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_judge (
    .thr_i    (thr_q),
    .mode_i   (mode_q),
    .sum_i    (sum_q),
    .count_i  (count_q),
    .mid_val_i(cell_val[mid_idx]),
    .all_in_i (all_in_q),
    .verdict_o(judge_verdict)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    all_in_d    = all_in_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    verdict_d   = verdict_q;
    ovf_out_d   = ovf_out_q;
    case (state_q)
      tswt_pkg::ST_COLLECT: begin
        if (in_acc) begin
          if (has_room) begin
            count_d  = count_q + CntW'(1);
            sum_d    = sum_q + SumW'(sample_i);
            all_in_d = all_in_q &&
                       tswt_pkg::in_window(tswt_pkg::ValW'(sample_i), thr_q);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_sample_i) begin
            state_d = tswt_pkg::ST_EVAL;
          end
        end
      end
      tswt_pkg::ST_EVAL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          verdict_d   = judge_verdict;
          ovf_out_d   = ovf_q;
          count_d     = '0;
          sum_d       = '0;
          all_in_d    = 1'b1;
          ovf_d       = 1'b0;
          state_d     = tswt_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_d = tswt_pkg::ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tswt_pkg::ST_COLLECT;
      thr_q       <= '0;
      mode_q      <= tswt_pkg::MODE_MEAN;
      count_q     <= '0;
      sum_q       <= '0;
      all_in_q    <= 1'b1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      all_in_q    <= all_in_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tswt_pkg::REG_THRESHOLD: thr_q  <= cfg_data_i;
          tswt_pkg::REG_TEST_MODE: mode_q <= cfg_data_i[tswt_pkg::ModeW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign overflow_o  = ovf_out_q;

`ifndef SYNTHESIS
  a_result_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == tswt_pkg::ST_EVAL))
    else $error("Result raised outside a verdict cycle.");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SAMPLES))
    else $error("Sample count exceeds the store depth.");

  a_last_enters_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_sample_i) |=> (state_q == tswt_pkg::ST_EVAL))
    else $error("Last sample did not start a verdict cycle.");

  a_run_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_fire |=> (count_q == '0) && all_in_q && !ovf_q)
    else $error("Run state not cleared after a verdict.");
`endif

endmodule
